// ===== rtl/eci_pkg.sv =====
package eci_pkg;

    localparam int VALUE_WIDTH_DEF     = 16;
    localparam int FRAC_BITS_DEF       = 15;
    localparam int SINE_TABLE_BITS_DEF = 8;

    localparam logic [2:0] KIND_LINEAR      = 3'd0;
    localparam logic [2:0] KIND_EASE_IN     = 3'd1;
    localparam logic [2:0] KIND_EASE_OUT    = 3'd2;
    localparam logic [2:0] KIND_EASE_IN_OUT = 3'd3;
    localparam logic [2:0] KIND_BOOMERANG   = 3'd4;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave sine entry in Q.30 by Taylor series, rounded to frac bits.
    // Evaluated at elaboration only, to fill the constant table.
    function automatic logic [63:0] sine_entry(input int idx, input int frac,
                                               input int tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        logic [63:0] one;
        x    = (HALF_PI_Q30 * 64'(idx)) >> tbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        one  = 64'd1 << frac;
        for (int k = 1; k <= 9; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        e = (sum + (64'd1 << (29 - frac))) >> (30 - frac);
        return (e > one) ? one : e;
    endfunction

endpackage

// ===== rtl/eci_divider_cell.sv =====
// One restoring-division step: shifts the partial remainder, subtracts the
// divisor where it fits, and hands everything on to the next cell.
module eci_divider_cell #(
    parameter int FRAC_BITS   = eci_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = eci_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [FRAC_BITS+2:0]          in_rem,
    input  logic [2*FRAC_BITS+1:0]        in_num,
    input  logic [FRAC_BITS+1:0]          in_den,
    input  logic [FRAC_BITS+1:0]          in_quo,
    input  logic [VALUE_WIDTH-1:0]        in_start,
    input  logic [VALUE_WIDTH:0]          in_span,
    input  logic                          in_zero,
    output logic                          out_valid,
    output logic [FRAC_BITS+2:0]          out_rem,
    output logic [2*FRAC_BITS+1:0]        out_num,
    output logic [FRAC_BITS+1:0]          out_den,
    output logic [FRAC_BITS+1:0]          out_quo,
    output logic [VALUE_WIDTH-1:0]        out_start,
    output logic [VALUE_WIDTH:0]          out_span,
    output logic                          out_zero
);
    import eci_pkg::*;

    logic [FRAC_BITS+3:0] shifted;
    logic [FRAC_BITS+3:0] diff;
    logic                 fits;

    assign shifted = {in_rem, in_num[2*FRAC_BITS+1]};
    assign diff    = shifted - {2'b00, in_den};
    assign fits    = !diff[FRAC_BITS+3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        out_rem   <= fits ? diff[FRAC_BITS+2:0] : shifted[FRAC_BITS+2:0];
        out_num   <= {in_num[2*FRAC_BITS:0], 1'b0};
        out_den   <= in_den;
        out_quo   <= {in_quo[FRAC_BITS:0], fits};
        out_start <= in_start;
        out_span  <= in_span;
        out_zero  <= in_zero;
    end

endmodule

// ===== rtl/easing_curve_interpolator.sv =====
// Channel | Direction | Ports                                        | Handshake
// input   | in        | kind, start_value, end_value, time_req       | start & !busy
// result  | out       | result                                       | done, one cycle
//
// One item per clock; busy is held low. An item taken with start shows on result
// with done once it has passed every register of the pipeline described below.
// One register for clamp, squares and table lookup (factor and divider
// operands are formed in front of the first cell), a row of 2*FRAC_BITS+2
// divider cells for the ease-in-out quotient, then multiply and round registers.
// All curve kinds travel the same row so results leave in order.
// Reset clears only the valid bits of the pipeline; payload is unreset.
// The receiver cannot stall: done is a pulse and result is valid with it.
module easing_curve_interpolator #(
    parameter int VALUE_WIDTH     = eci_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS       = eci_pkg::FRAC_BITS_DEF,
    parameter int SINE_TABLE_BITS = eci_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    kind,
    input  logic signed [VALUE_WIDTH-1:0] start_value,
    input  logic signed [VALUE_WIDTH-1:0] end_value,
    input  logic signed [FRAC_BITS+1:0]   time_req,
    output logic                          done,
    output logic signed [VALUE_WIDTH-1:0] result
);
    import eci_pkg::*;

    localparam int FW        = FRAC_BITS + 1;          // factor width, 0..ONE
    localparam int ROM_N     = (1 << SINE_TABLE_BITS) + 1;
    localparam int NCELL     = 2 * FRAC_BITS + 2;      // quotient bits
    localparam logic [FW-1:0] ONE  = FW'(1) << FRAC_BITS;
    localparam logic [FW-1:0] HALF = FW'(1) << (FRAC_BITS - 1);

    typedef logic [FW-1:0] rom_t [ROM_N];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < ROM_N; i++)
            r[i] = FW'(sine_entry(i, FRAC_BITS, SINE_TABLE_BITS));
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    assign busy = 1'b0;

    // ---------------- stage 1: clamp, squares, sine argument
    logic [FW-1:0] t_c;
    always_comb
    begin
        if (time_req[FRAC_BITS+1])
            t_c = '0;
        else if (time_req[FRAC_BITS:0] > ONE)
            t_c = ONE;
        else
            t_c = time_req[FRAC_BITS:0];
    end

    logic [2*FW-1:0] sq_a;
    logic [2*FW-1:0] sq_b;
    logic [FW-1:0]   t_inv;
    logic [FW-1:0]   sin_arg;
    assign t_inv = ONE - t_c;
    assign sq_a  = t_c * t_c + (2*FW)'(HALF);
    assign sq_b  = t_inv * t_inv + (2*FW)'(HALF);

    always_comb
    begin
        case (kind)
            KIND_BOOMERANG:
                sin_arg = (t_c <= HALF) ? FW'({t_c, 1'b0}) : FW'({t_inv, 1'b0});
            default:
                sin_arg = t_c;
        endcase
    end

    logic                          s1_valid_reg;
    logic [2:0]                    s1_kind_reg;
    logic [FW-1:0]                 s1_t_reg;
    logic [FW-1:0]                 s1_a_reg;
    logic [FW-1:0]                 s1_b_reg;
    logic [FW-1:0]                 s1_sin_lo_reg;
    logic [FW-1:0]                 s1_sin_hi_reg;
    logic [FRAC_BITS-1:0]          s1_frac_reg;
    logic [VALUE_WIDTH-1:0]        s1_start_reg;
    logic [VALUE_WIDTH:0]          s1_span_reg;

    logic [FRAC_BITS+SINE_TABLE_BITS:0] pos;
    logic [SINE_TABLE_BITS:0]           ridx;
    logic [SINE_TABLE_BITS:0]           ridx_hi;
    assign pos     = {sin_arg, {SINE_TABLE_BITS{1'b0}}};
    assign ridx    = pos[FRAC_BITS+SINE_TABLE_BITS:FRAC_BITS];
    assign ridx_hi = ridx[SINE_TABLE_BITS] ? ridx : ridx + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg   <= kind;
        s1_t_reg      <= t_c;
        s1_a_reg      <= sq_a[FRAC_BITS+FW-1:FRAC_BITS];
        s1_b_reg      <= sq_b[FRAC_BITS+FW-1:FRAC_BITS];
        s1_sin_lo_reg <= SINE_ROM[ridx];
        s1_sin_hi_reg <= SINE_ROM[ridx_hi];
        s1_frac_reg   <= ridx[SINE_TABLE_BITS] ? '0 : pos[FRAC_BITS-1:0];
        s1_start_reg  <= start_value;
        s1_span_reg   <= (VALUE_WIDTH+1)'(end_value) - (VALUE_WIDTH+1)'(start_value);
    end

    // ---------------- stage 2: factor, divider operands
    logic [FW-1:0]            hi_fix;
    logic [FW+FRAC_BITS-1:0]  sin_prod;
    logic [FW-1:0]            sin_val;
    logic [FW:0]              ab_sum;
    assign hi_fix   = (s1_sin_hi_reg < s1_sin_lo_reg) ? s1_sin_lo_reg : s1_sin_hi_reg;
    assign sin_prod = (hi_fix - s1_sin_lo_reg) * s1_frac_reg + (FW+FRAC_BITS)'(HALF);
    assign sin_val  = s1_sin_lo_reg + sin_prod[FW+FRAC_BITS-1:FRAC_BITS];
    assign ab_sum   = {1'b0, s1_a_reg} + {1'b0, s1_b_reg};

    logic [FW-1:0] fac;
    logic          direct;
    logic          zero_out;
    always_comb
    begin
        direct   = 1'b1;
        zero_out = 1'b0;
        case (s1_kind_reg)
            KIND_LINEAR:      fac = s1_t_reg;
            KIND_EASE_IN:     fac = s1_a_reg;
            KIND_EASE_OUT:    fac = sin_val;
            KIND_BOOMERANG:   fac = sin_val;
            KIND_EASE_IN_OUT:
            begin
                fac    = '0;
                direct = 1'b0;
            end
            default:
            begin
                fac      = '0;
                zero_out = 1'b1;
            end
        endcase
    end

    // Direct kinds go through the row as numerator fac*2^FRAC_BITS with
    // divisor ONE: quotient is exact, so the row carries every kind.
    logic [2*FRAC_BITS+1:0] d_num;
    logic [FRAC_BITS+1:0]   d_den;
    always_comb
    begin
        if (direct)
        begin
            d_num = (2*FRAC_BITS+2)'(fac) << FRAC_BITS;
            d_den = (FRAC_BITS+2)'(ONE);
        end
        else if (ab_sum == '0)
        begin
            d_num = '0;
            d_den = (FRAC_BITS+2)'(ONE);
        end
        else
        begin
            d_num = ((2*FRAC_BITS+2)'(s1_a_reg) << FRAC_BITS)
                  + (2*FRAC_BITS+2)'(ab_sum >> 1);
            d_den = (FRAC_BITS+2)'(ab_sum);
        end
    end

    // ---------------- divider row
    logic                   c_valid [NCELL+1];
    logic [FRAC_BITS+2:0]   c_rem   [NCELL+1];
    logic [2*FRAC_BITS+1:0] c_num   [NCELL+1];
    logic [FRAC_BITS+1:0]   c_den   [NCELL+1];
    logic [FRAC_BITS+1:0]   c_quo   [NCELL+1];
    logic [VALUE_WIDTH-1:0] c_start [NCELL+1];
    logic [VALUE_WIDTH:0]   c_span  [NCELL+1];
    logic                   c_zero  [NCELL+1];

    assign c_valid[0] = s1_valid_reg;
    assign c_rem[0]   = '0;
    assign c_num[0]   = d_num;
    assign c_den[0]   = d_den;
    assign c_quo[0]   = '0;
    assign c_start[0] = s1_start_reg;
    assign c_span[0]  = s1_span_reg;
    assign c_zero[0]  = zero_out;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        eci_divider_cell #(
            .FRAC_BITS   (FRAC_BITS),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[g]),
            .in_rem    (c_rem[g]),
            .in_num    (c_num[g]),
            .in_den    (c_den[g]),
            .in_quo    (c_quo[g]),
            .in_start  (c_start[g]),
            .in_span   (c_span[g]),
            .in_zero   (c_zero[g]),
            .out_valid (c_valid[g+1]),
            .out_rem   (c_rem[g+1]),
            .out_num   (c_num[g+1]),
            .out_den   (c_den[g+1]),
            .out_quo   (c_quo[g+1]),
            .out_start (c_start[g+1]),
            .out_span  (c_span[g+1]),
            .out_zero  (c_zero[g+1])
        );
    end

    // ---------------- multiply and round
    logic [FW-1:0] f_cap;
    assign f_cap = (c_quo[NCELL] > (FRAC_BITS+2)'(ONE)) ? ONE : c_quo[NCELL][FW-1:0];

    logic                                m_valid_reg;
    logic signed [VALUE_WIDTH+FW+1:0]    m_prod_reg;
    logic [VALUE_WIDTH-1:0]              m_start_reg;
    logic                                m_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            done        <= 1'b0;
        end
        else
        begin
            m_valid_reg <= c_valid[NCELL];
            done        <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_prod_reg  <= $signed(c_span[NCELL]) * $signed({1'b0, f_cap});
        m_start_reg <= c_start[NCELL];
        m_zero_reg  <= c_zero[NCELL];
    end

    // floor((p + HALF) / ONE) is exactly round half up; arithmetic shift floors.
    logic signed [VALUE_WIDTH+FW+1:0] rnd;
    logic signed [VALUE_WIDTH+FW+1:0] q;
    assign rnd = m_prod_reg + (VALUE_WIDTH+FW+2)'(HALF);
    assign q   = rnd >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (m_zero_reg)
            result <= '0;
        else
            result <= m_start_reg + q[VALUE_WIDTH-1:0];
    end

endmodule
